// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl modules, included by wmco_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define WMCO_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// same-cycle implication
`define WMCO_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wmco_pkg.sv =====
// shared types and constants of the windowed minimum clock offset filter
`default_nettype none

package wmco_pkg;

    localparam int TIME_W = 63;
    localparam int OFS_W  = 64;
    localparam int LEAD_W = 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_CLEAR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic sub;
        logic write;
        logic scan;
        logic clear;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/wmco_if.sv =====
// sample and result channel interfaces
`default_nettype none

interface wmco_smp_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [wmco_pkg::TIME_W-1:0]   server_time_us;
    logic [wmco_pkg::TIME_W-1:0]   local_time_us;

    modport source (output valid, output req_type, output server_time_us,
                    output local_time_us, input ready);
    modport sink   (input valid, input req_type, input server_time_us,
                    input local_time_us, output ready);
endinterface

interface wmco_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [wmco_pkg::OFS_W-1:0]  offset_us;
    logic signed [wmco_pkg::OFS_W-1:0]  drift_us;
    logic signed [wmco_pkg::OFS_W-1:0]  est_now_us;
    logic                               window_full;

    modport source (output valid, output offset_us, output drift_us,
                    output est_now_us, output window_full, input ready);
    modport sink   (input valid, input offset_us, input drift_us,
                    input est_now_us, input window_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wmco_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module wmco_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/wmco_ctrl.sv =====
// controller state machine sequencing one item through the datapath
`default_nettype none
`include "assert_macros.svh"

module wmco_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_clear,
    output logic                o_in_ready,
    input  wire wmco_pkg::t_sts i_sts,
    output wmco_pkg::t_cmd      o_cmd
);

    wmco_pkg::t_state r_state;
    wmco_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmco_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmco_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_clear ? wmco_pkg::S_CLEAR : wmco_pkg::S_SUB;
                end
            end
            wmco_pkg::S_SUB:   n_state = wmco_pkg::S_WRITE;
            wmco_pkg::S_WRITE: n_state = wmco_pkg::S_SCAN;
            wmco_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = wmco_pkg::S_DRAIN;
                end
            end
            wmco_pkg::S_DRAIN: n_state = wmco_pkg::S_FINISH;
            wmco_pkg::S_CLEAR: n_state = wmco_pkg::S_FINISH;
            wmco_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = wmco_pkg::S_IDLE;
                end
            end
            default: n_state = wmco_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wmco_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            wmco_pkg::S_SUB:    o_cmd.sub   = 1'b1;
            wmco_pkg::S_WRITE:  o_cmd.write = 1'b1;
            wmco_pkg::S_SCAN:   o_cmd.scan  = 1'b1;
            wmco_pkg::S_DRAIN:  o_cmd       = '0;
            wmco_pkg::S_CLEAR:  o_cmd.clear = 1'b1;
            wmco_pkg::S_FINISH: o_cmd.emit  = i_sts.out_free;
            default:            o_cmd       = '0;
        endcase
    end

    `WMCO_ASSERT_ALWAYS(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd), "more than one command")
    `WMCO_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "emit into busy output")
    `WMCO_ASSERT_IMPLY(a_drain_after_scan, i_clk, i_rst_n, r_state == wmco_pkg::S_DRAIN, $past(r_state) == wmco_pkg::S_SCAN, "drain not after scan")

endmodule

`default_nettype wire

// ===== rtl/core/wmco_dpath.sv =====
// datapath: offset forming, sample ring, minimum scan, baseline and output register
`default_nettype none

module wmco_dpath #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire wmco_pkg::t_cmd                    i_cmd,
    output wmco_pkg::t_sts                         o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [wmco_pkg::LEAD_W-1:0]       i_cfg_wdata,
    input  wire logic [wmco_pkg::TIME_W-1:0]       i_server_time_us,
    input  wire logic [wmco_pkg::TIME_W-1:0]       i_local_time_us,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [wmco_pkg::OFS_W-1:0]      o_offset_us,
    output logic signed [wmco_pkg::OFS_W-1:0]      o_drift_us,
    output logic signed [wmco_pkg::OFS_W-1:0]      o_est_now_us,
    output logic                                   o_window_full
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int OW = wmco_pkg::OFS_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [wmco_pkg::LEAD_W-1:0] r_lead;
    logic [IW-1:0]               r_wptr;
    logic                        r_full;
    logic [OW-1:0]               r_base;
    logic                        r_rd_vld;
    logic                        r_out_valid;

    logic [OW-1:0]               r_diff;
    logic [OW-1:0]               r_sample;
    logic [wmco_pkg::TIME_W-1:0] r_loc;
    logic [IW-1:0]               r_last_idx;
    logic [IW-1:0]               r_idx;
    logic                        r_rd_first;
    logic [OW-1:0]               r_best;
    logic [OW-1:0]               r_out_offset;
    logic [OW-1:0]               r_out_drift;
    logic [OW-1:0]               r_out_now;
    logic                        r_out_full;

    logic [OW-1:0]               w_rdata;
    logic [OW-1:0]               n_base;
    logic [OW-1:0]               n_drift;
    logic                        w_take;

    wmco_ram #(
        .WIDTH (OW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // zero baseline means unset; latch the first full-window minimum
    always_comb begin
        n_base  = (r_base == '0 && r_full) ? r_best : r_base;
        n_drift = (n_base == '0) ? '0 : r_best - n_base;
    end

    assign w_take = r_rd_vld && (r_rd_first || $signed(w_rdata) < $signed(r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead      <= '0;
            r_wptr      <= '0;
            r_full      <= 1'b0;
            r_base      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lead <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_wptr <= '0;
                r_full <= 1'b0;
                r_base <= '0;
            end else if (i_cmd.write) begin
                if (r_wptr == LAST_IDX) begin
                    r_wptr <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end else if (i_cmd.emit) begin
                r_base <= n_base;
            end
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff <= {1'b0, i_server_time_us} - {1'b0, i_local_time_us};
            r_loc  <= i_local_time_us;
        end
        if (i_cmd.clear) begin
            r_loc  <= '0;
            r_best <= '0;
        end
        if (i_cmd.sub) begin
            r_sample <= r_diff - {{(OW - wmco_pkg::LEAD_W){1'b0}}, r_lead};
        end
        if (i_cmd.write) begin
            r_idx      <= '0;
            r_last_idx <= (r_full || r_wptr == LAST_IDX) ? LAST_IDX : r_wptr;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
        end
        r_rd_first <= (r_idx == '0);
        if (w_take) begin
            r_best <= w_rdata;
        end
        if (i_cmd.emit) begin
            r_out_offset <= r_best;
            r_out_drift  <= n_drift;
            r_out_now    <= {1'b0, r_loc} + r_best;
            r_out_full   <= r_full;
        end
    end

    assign o_sts.scan_last = (r_idx == r_last_idx);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_offset_us     = $signed(r_out_offset);
    assign o_drift_us      = $signed(r_out_drift);
    assign o_est_now_us    = $signed(r_out_now);
    assign o_window_full   = r_out_full;

endmodule

`default_nettype wire

// ===== rtl/core/windowed_min_clock_offset.sv =====
// top level of the windowed minimum clock offset filter
// sequence: a sample is accepted, the lead is subtracted, the offset goes into the ring,
//   every written ring entry (RING_DEPTH once full) is scanned for the minimum, the last
//   read drains and the result is emitted; a clear empties the ring and emits a result
// items are taken one at a time; a finished result waits in the output register
// reset: synchronous active-low i_rst_n empties the ring, unsets the baseline, zeroes the lead
`default_nettype none

module windowed_min_clock_offset #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // playback lead register write
    input  wire logic                        i_cfg_we,
    input  wire logic [wmco_pkg::LEAD_W-1:0] i_cfg_wdata,
    // sample and result channels
    wmco_smp_if.sink                         i_smp,
    wmco_res_if.source                       o_res
);

    wmco_pkg::t_cmd w_cmd;
    wmco_pkg::t_sts w_sts;
    logic           w_in_ready;

    // sequencer: accept, subtract lead, write ring, scan, drain read, finish; or accept, clear, finish
    wmco_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_in_clear (i_smp.req_type),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // ring, comparator and output register; the result register parts the two channels
    wmco_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_server_time_us (i_smp.server_time_us),
        .i_local_time_us  (i_smp.local_time_us),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_offset_us      (o_res.offset_us),
        .o_drift_us       (o_res.drift_us),
        .o_est_now_us     (o_res.est_now_us),
        .o_window_full    (o_res.window_full)
    );

    // transfer on the sample side only while the sequencer is idle
    assign i_smp.ready = w_in_ready;

endmodule

`default_nettype wire
